FILE: sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_END        = 3'd1;
   localparam logic [2:0] ERR_MISSING_U  = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
   localparam logic [2:0] ERR_BAD_LOW    = 3'd4;
   localparam logic [2:0] ERR_NO_QUOTE   = 3'd5;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_FF     = 8'h0c;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   // surrogate ranges, top six bits of the code unit
   localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;  // d800..dbff
   localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;  // dc00..dfff
   localparam logic [10:0] SURR_OFFSET   = 11'h040;

   // parser phase
   typedef enum logic [2:0] {
      PH_WAIT,
      PH_BODY,
      PH_ESC,
      PH_HEX,
      PH_NEED_BS,
      PH_NEED_U
   } jsu_phase_type;

   // one decoded job between front and back
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  err;
      logic [1:0]  last_idx;  // number of UTF-8 bytes minus one
      logic [20:0] wc;        // code point, or raw byte for plain data
   } jsu_job_type;

   // hex digit decode: {valid, value}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

FILE: sv/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser front end: takes one byte per beat, tracks string and escape state,
// and turns each byte that yields output into one job for the back end.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        queue_full,
   output logic        push,
   output jsu_job_type push_job
);

   jsu_phase_type phase_ff, phase_in;
   logic [11:0]   hex_ff, hex_in;
   logic [1:0]    digits_ff, digits_in;
   logic [9:0]    high_ff, high_in;
   logic          pend_ff, pend_in;

   logic          accept;
   logic [4:0]    nib;
   logic [15:0]   unit;
   logic [10:0]   plane;
   logic [7:0]    c;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_in_byte;
   assign nib       = hex_nibble(c);
   assign unit      = {hex_ff, nib[3:0]};
   assign plane     = {1'b0, high_ff} + SURR_OFFSET;

   // next state and job
   always_comb begin
      phase_in  = phase_ff;
      hex_in    = hex_ff;
      digits_in = digits_ff;
      high_in   = high_ff;
      pend_in   = pend_ff;
      push      = 1'b0;
      push_job  = '{kind: KIND_DATA, err: ERR_NONE, last_idx: 2'd0, wc: 21'd0};

      unique case (phase_ff)
         PH_BODY: begin
            if (c == CH_NUL) begin
               push_job.kind = KIND_ERROR;
               push_job.err  = ERR_END;
               push          = 1'b1;
               phase_in      = PH_WAIT;
            end else if (c == CH_QUOTE) begin
               push_job.kind = KIND_DONE;
               push          = 1'b1;
               phase_in      = PH_WAIT;
            end else if (c == CH_BSLASH) begin
               phase_in = PH_ESC;
            end else begin
               push_job.wc = {13'd0, c};
               push        = 1'b1;
            end
         end
         PH_ESC: begin
            if (c == CH_NUL) begin
               push_job.kind = KIND_ERROR;
               push_job.err  = ERR_END;
               push          = 1'b1;
               phase_in      = PH_WAIT;
            end else if (c == CH_LOW_U) begin
               phase_in  = PH_HEX;
               hex_in    = '0;
               digits_in = '0;
            end else begin
               phase_in = PH_BODY;
               push     = 1'b1;
               priority case (c)
                  CH_LOW_B: push_job.wc = {13'd0, CH_BS};
                  CH_LOW_F: push_job.wc = {13'd0, CH_FF};
                  CH_LOW_N: push_job.wc = {13'd0, CH_LF};
                  CH_LOW_R: push_job.wc = {13'd0, CH_CR};
                  CH_LOW_T: push_job.wc = {13'd0, CH_TAB};
                  default:  push_job.wc = {13'd0, c};
               endcase
            end
         end
         PH_HEX: begin
            if (c == CH_NUL || !nib[4]) begin
               push_job.kind = KIND_ERROR;
               push_job.err  = (c == CH_NUL) ? ERR_END : ERR_BAD_HEX;
               push          = 1'b1;
               phase_in      = PH_WAIT;
               hex_in        = '0;
               digits_in     = '0;
               high_in       = '0;
               pend_in       = 1'b0;
            end else if (digits_ff != 2'd3) begin
               hex_in    = {hex_ff[7:0], nib[3:0]};
               digits_in = digits_ff + 2'd1;
            end else begin
               // four digits in: one full code unit
               hex_in    = '0;
               digits_in = '0;
               if (pend_ff) begin
                  if (unit[15:10] != SURR_LOW_TAG) begin
                     push_job.kind = KIND_ERROR;
                     push_job.err  = ERR_BAD_LOW;
                     phase_in      = PH_WAIT;
                  end else begin
                     push_job.wc       = {plane, unit[9:0]};
                     push_job.last_idx = 2'd3;
                     phase_in          = PH_BODY;
                  end
                  push    = 1'b1;
                  high_in = '0;
                  pend_in = 1'b0;
               end else if (unit[15:10] == SURR_HIGH_TAG) begin
                  high_in  = unit[9:0];
                  pend_in  = 1'b1;
                  phase_in = PH_NEED_BS;
               end else begin
                  push        = 1'b1;
                  phase_in    = PH_BODY;
                  push_job.wc = {5'd0, unit};
                  if (unit < 16'h0080) begin
                     push_job.last_idx = 2'd0;
                  end else if (unit < 16'h0800) begin
                     push_job.last_idx = 2'd1;
                  end else begin
                     push_job.last_idx = 2'd2;
                  end
               end
            end
         end
         PH_NEED_BS, PH_NEED_U: begin
            if (c == CH_NUL || c != ((phase_ff == PH_NEED_BS) ? CH_BSLASH : CH_LOW_U))
            begin
               push_job.kind = KIND_ERROR;
               push_job.err  = (c == CH_NUL) ? ERR_END : ERR_MISSING_U;
               push          = 1'b1;
               phase_in      = PH_WAIT;
               high_in       = '0;
               pend_in       = 1'b0;
            end else if (phase_ff == PH_NEED_BS) begin
               phase_in = PH_NEED_U;
            end else begin
               phase_in  = PH_HEX;
               hex_in    = '0;
               digits_in = '0;
            end
         end
         default: begin
            // waiting for the opening quote
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
               phase_in = PH_WAIT;
            end else if (c == CH_QUOTE) begin
               phase_in  = PH_BODY;
               hex_in    = '0;
               digits_in = '0;
               high_in   = '0;
               pend_in   = 1'b0;
            end else begin
               push_job.kind = KIND_ERROR;
               push_job.err  = (c == CH_NUL) ? ERR_END : ERR_NO_QUOTE;
               push          = 1'b1;
               phase_in      = PH_WAIT;
            end
         end
      endcase

      if (!accept) begin
         push = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         hex_ff    <= '0;
         digits_ff <= '0;
         high_ff   <= '0;
         pend_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hex_ff    <= hex_in;
         digits_ff <= digits_in;
         high_ff   <= high_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

FILE: sv/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small job FIFO between front and back; head entry is read directly.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  jsu_job_type push_job,
   output logic        full,
   input  logic        pop,
   output logic        empty,
   output jsu_job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_job_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: sv/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Back end: expands the head job into one to four UTF-8 result beats and
// holds each in the output register until it is taken.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  jsu_job_type head_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);

   logic       valid_ff;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] err_ff;
   logic       last_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       at_end;

   assign load   = !valid_ff || rsp_ready;
   assign at_end = (idx_ff == head_job.last_idx);
   assign pop    = load && !empty && at_end;

   // byte select for the current beat
   always_comb begin
      unique case ({head_job.last_idx, idx_ff})
         4'b00_00: byte_in = head_job.wc[7:0];
         4'b01_00: byte_in = {3'b110, head_job.wc[10:6]};
         4'b01_01: byte_in = {2'b10, head_job.wc[5:0]};
         4'b10_00: byte_in = {4'b1110, head_job.wc[15:12]};
         4'b10_01: byte_in = {2'b10, head_job.wc[11:6]};
         4'b10_10: byte_in = {2'b10, head_job.wc[5:0]};
         4'b11_00: byte_in = {5'b11110, head_job.wc[20:18]};
         4'b11_01: byte_in = {2'b10, head_job.wc[17:12]};
         4'b11_10: byte_in = {2'b10, head_job.wc[11:6]};
         4'b11_11: byte_in = {2'b10, head_job.wc[5:0]};
         default:  byte_in = 8'd0;
      endcase
      idx_in = idx_ff;
      if (load && !empty) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            valid_ff <= !empty;
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load && !empty) begin
         kind_ff <= head_job.kind;
         byte_ff <= byte_in;
         err_ff  <= head_job.err;
         last_ff <= at_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_error_code = err_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: sv/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body decoder, one input byte per beat, UTF-8 bytes out.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle for as long as its job queue has
// room, and gives one result beat per cycle while the result side is ready.
// A byte that yields output puts one job in the queue; the back end turns
// each job into its result beats, so a plain byte, string end or error gives
// one beat and a \u escape gives one to four (four for a surrogate pair). The
// back end's one beat per cycle sets the sustained rate; the QUEUE_DEPTH job
// queue takes up bursts. The first result beat of an input byte passes
// through the job queue and then the output register before it is presented.
// After an error or a closing quote the block waits for the next opening quote.
module json_string_unescape_utf8 import jsu_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   logic        push;
   logic        pop;
   logic        full;
   logic        empty;
   jsu_job_type push_job;
   jsu_job_type head_job;

   // parser
   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .queue_full  (full),
      .push        (push),
      .push_job    (push_job)
   );

   // job queue
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head_job (head_job)
   );

   // UTF-8 emitter
   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (empty),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: sv/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the unescaper's result channel.
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_error_code,
   input logic       rsp_last
);

   // no beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_byte) && $stable(rsp_error_code) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // completion and error are single, final beats with no data
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DATA |-> rsp_last && rsp_out_byte == 8'd0)
      else $error("status beat not last or carries data");

   // error code only on error beats
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_error_code == ERR_NONE)
      else $error("error code on non-error beat");

   // a UTF-8 lead byte follows a final beat
   a_lead_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_DATA && rsp_out_byte[7:6] == 2'b11
         |-> !$past(rsp_valid) || $past(rsp_last) || !$past(rsp_ready)
            || $past(rsp_kind) != KIND_DATA)
      else $error("lead byte inside a multi-byte sequence");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_error_code (rsp_error_code),
   .rsp_last       (rsp_last)
);

FILE: test/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// Self-checking bench for the JSON string unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// A short scripted byte stream covers whitespace skipping, the opening quote,
// the byte extremes, \u0000 and the largest surrogate pair, checked against
// its expected beats. Random strings follow, mostly well formed: plain bytes,
// escapes, \u units of every UTF-8 length, lone low surrogates and surrogate
// pairs, some ended by an injected error, checked against a behavioral decoder
// run on each accepted input beat. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
   import jsu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TARGET_BYTES   = 255;

   // one result beat
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [2:0] err;
      logic       last_beat;
   } beat_type;

   // one row of the scripted stream; want is used only when typed is set
   typedef struct packed {
      logic [7:0] ch;
      logic       typed;
      beat_type   want;
   } script_row_type;

   localparam beat_type NO_BEAT = '0;
   localparam int N_SCRIPT = 27;
   localparam script_row_type SCRIPT [N_SCRIPT] = '{
      '{CH_SPACE,  1'b0, NO_BEAT},
      '{CH_TAB,    1'b0, NO_BEAT},
      '{CH_CR,     1'b0, NO_BEAT},
      '{CH_LF,     1'b0, NO_BEAT},
      '{"x",       1'b1, '{KIND_ERROR, 8'h00, ERR_NO_QUOTE, 1'b1}},
      '{CH_NUL,    1'b1, '{KIND_ERROR, 8'h00, ERR_END, 1'b1}},
      '{CH_QUOTE,  1'b0, NO_BEAT},
      '{8'hff,     1'b1, '{KIND_DATA, 8'hff, ERR_NONE, 1'b1}},
      // \u0000 gives a zero data byte
      '{CH_BSLASH, 1'b0, NO_BEAT},
      '{CH_LOW_U,  1'b0, NO_BEAT},
      '{"0",       1'b0, NO_BEAT},
      '{"0",       1'b0, NO_BEAT},
      '{"0",       1'b0, NO_BEAT},
      '{"0",       1'b1, '{KIND_DATA, 8'h00, ERR_NONE, 1'b1}},
      // \udbff\uDFFF, the highest code point
      '{CH_BSLASH, 1'b0, NO_BEAT},
      '{CH_LOW_U,  1'b0, NO_BEAT},
      '{"d",       1'b0, NO_BEAT},
      '{"b",       1'b0, NO_BEAT},
      '{"f",       1'b0, NO_BEAT},
      '{"f",       1'b0, NO_BEAT},
      '{CH_BSLASH, 1'b0, NO_BEAT},
      '{CH_LOW_U,  1'b0, NO_BEAT},
      '{"D",       1'b0, NO_BEAT},
      '{"F",       1'b0, NO_BEAT},
      '{"F",       1'b0, NO_BEAT},
      '{"F",       1'b0, NO_BEAT},
      '{CH_QUOTE,  1'b1, '{KIND_DONE, 8'h00, ERR_NONE, 1'b1}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_error_code;
   logic       rsp_last;

   always #4 clock = ~clock;

   json_string_unescape_utf8 u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   // decoder state
   jsu_phase_type st_phase;
   logic [15:0]   st_hex;
   logic [1:0]    st_ndigits;
   logic [9:0]    st_high;
   logic          st_pair;

   beat_type fresh_beats [$];   // beats of the byte being decoded
   beat_type beats_due [$];     // decoded beats still to come from the block

   bit calm = 1'b0;          // no idling on either side while set
   int n_sent = 0;
   int n_fail = 0;
   int n_data = 0;
   int n_done = 0;
   int n_err  = 0;

   // ----------------------------------------------------------------------
   // Behavioral decoder
   // ----------------------------------------------------------------------
   function automatic void clear_state();
      st_phase   = PH_WAIT;
      st_hex     = '0;
      st_ndigits = '0;
      st_high    = '0;
      st_pair    = 1'b0;
   endfunction

   function automatic void emit(input logic [1:0] k, input logic [7:0] b,
                                input logic [2:0] e);
      beat_type bt;
      bt = '{k, b, e, 1'b0};
      fresh_beats = {fresh_beats, bt};
   endfunction

   function automatic void abort(input logic [2:0] e);
      clear_state();
      emit(KIND_ERROR, 8'h00, e);
   endfunction

   // {valid, value} of a hex digit, either case
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
      if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
      if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
      return 5'd0;
   endfunction

   // one complete \u code unit: pair it up or encode it as UTF-8
   function automatic void encode_unit(input logic [15:0] cu);
      logic [20:0] wc;
      if (st_pair) begin
         if (cu[15:10] != SURR_LOW_TAG) begin
            abort(ERR_BAD_LOW);
            return;
         end
         wc = {11'(st_high) + SURR_OFFSET, cu[9:0]};
         st_pair = 1'b0;
         st_high = '0;
      end else if (cu[15:10] == SURR_HIGH_TAG) begin
         st_high  = cu[9:0];
         st_pair  = 1'b1;
         st_phase = PH_NEED_BS;
         return;
      end else begin
         wc = {5'd0, cu};
      end
      st_phase = PH_BODY;
      if (wc < 21'h80) begin
         emit(KIND_DATA, wc[7:0], ERR_NONE);
      end else if (wc < 21'h800) begin
         emit(KIND_DATA, {3'b110, wc[10:6]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, wc[5:0]}, ERR_NONE);
      end else if (wc < 21'h10000) begin
         emit(KIND_DATA, {4'b1110, wc[15:12]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, wc[11:6]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, wc[5:0]}, ERR_NONE);
      end else begin
         emit(KIND_DATA, {5'b11110, wc[20:18]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, wc[17:12]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, wc[11:6]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, wc[5:0]}, ERR_NONE);
      end
   endfunction

   // decode one input byte into fresh_beats
   function automatic void unescape_byte(input logic [7:0] c);
      logic [4:0]  dig;
      logic [15:0] cu;
      fresh_beats.delete();
      case (st_phase)
         PH_BODY: begin
            if (c == CH_NUL) abort(ERR_END);
            else if (c == CH_QUOTE) begin
               clear_state();
               emit(KIND_DONE, 8'h00, ERR_NONE);
            end else if (c == CH_BSLASH) st_phase = PH_ESC;
            else emit(KIND_DATA, c, ERR_NONE);
         end
         PH_ESC: begin
            if (c == CH_NUL) abort(ERR_END);
            else if (c == CH_LOW_U) begin
               st_phase   = PH_HEX;
               st_hex     = '0;
               st_ndigits = '0;
            end else begin
               st_phase = PH_BODY;
               case (c)
                  CH_LOW_B: emit(KIND_DATA, CH_BS, ERR_NONE);
                  CH_LOW_F: emit(KIND_DATA, CH_FF, ERR_NONE);
                  CH_LOW_N: emit(KIND_DATA, CH_LF, ERR_NONE);
                  CH_LOW_R: emit(KIND_DATA, CH_CR, ERR_NONE);
                  CH_LOW_T: emit(KIND_DATA, CH_TAB, ERR_NONE);
                  default:  emit(KIND_DATA, c, ERR_NONE);
               endcase
            end
         end
         PH_HEX: begin
            dig = hex_digit(c);
            if (c == CH_NUL) abort(ERR_END);
            else if (!dig[4]) abort(ERR_BAD_HEX);
            else begin
               st_hex = {st_hex[11:0], dig[3:0]};
               if (st_ndigits != 2'd3) st_ndigits = st_ndigits + 2'd1;
               else begin
                  st_ndigits = '0;
                  cu         = st_hex;
                  st_hex     = '0;
                  encode_unit(cu);
               end
            end
         end
         PH_NEED_BS: begin
            if (c == CH_NUL) abort(ERR_END);
            else if (c != CH_BSLASH) abort(ERR_MISSING_U);
            else st_phase = PH_NEED_U;
         end
         PH_NEED_U: begin
            if (c == CH_NUL) abort(ERR_END);
            else if (c != CH_LOW_U) abort(ERR_MISSING_U);
            else begin
               st_phase   = PH_HEX;
               st_hex     = '0;
               st_ndigits = '0;
            end
         end
         default: begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
               // skipped
            end else if (c == CH_QUOTE) begin
               clear_state();
               st_phase = PH_BODY;
            end else if (c == CH_NUL) abort(ERR_END);
            else abort(ERR_NO_QUOTE);
         end
      endcase
      if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size() - 1].last_beat = 1'b1;
   endfunction

   // ----------------------------------------------------------------------
   // Input side
   // ----------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // drive one input beat, wait for accept, then queue its expected beats
   task automatic send_byte(input logic [7:0] ch, input logic typed = 1'b0,
                            input beat_type want = '0);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
      unescape_byte(ch);
      if (typed) beats_due = {beats_due, want};
      else beats_due = {beats_due, fresh_beats};
   endtask

   // hold the input idle until every due beat has arrived
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (beats_due.size() != 0);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (($urandom_range(0, 1) == 0) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
   endfunction

   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
      return c;
   endfunction

   function automatic logic [7:0] pick_escaped();
      logic [7:0] c;
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 7))
            0: c = CH_QUOTE;
            1: c = CH_BSLASH;
            2: c = "/";
            3: c = CH_LOW_B;
            4: c = CH_LOW_F;
            5: c = CH_LOW_N;
            6: c = CH_LOW_R;
            default: c = CH_LOW_T;
         endcase
      end else begin
         do c = 8'($urandom_range(1, 255)); while (c == CH_LOW_U);
      end
      return c;
   endfunction

   // 0 one byte, 1 two bytes, 2 three bytes, 3 lone low surrogate
   function automatic logic [15:0] pick_unit(input int cls);
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] cu;
      int r;
      case (cls)
         0: begin lo = 16'h0000; hi = 16'h007f; end
         1: begin lo = 16'h0080; hi = 16'h07ff; end
         2: begin lo = 16'h0800; hi = 16'hffff; end
         default: begin lo = 16'hdc00; hi = 16'hdfff; end
      endcase
      r = $urandom_range(0, 7);
      if (r == 0) return lo;
      if (r == 1) return hi;
      cu = 16'($urandom_range(lo, hi));
      // keep three-byte units out of the surrogate block
      if (cls == 2 && cu[15:11] == 5'b11011) cu[15:11] = 5'b11101;
      return cu;
   endfunction

   task automatic send_unit(input logic [15:0] cu);
      send_byte(CH_BSLASH);
      send_byte(CH_LOW_U);
      send_byte(hex_char(cu[15:12]));
      send_byte(hex_char(cu[11:8]));
      send_byte(hex_char(cu[7:4]));
      send_byte(hex_char(cu[3:0]));
   endtask

   // \u with zero to three good digits, then the given byte
   task automatic send_cut_unit(input logic [7:0] tail);
      int k;
      int i;
      k = $urandom_range(0, 3);
      send_byte(CH_BSLASH);
      send_byte(CH_LOW_U);
      for (i = 0; i < k; i++) send_byte(hex_char(4'($urandom_range(0, 15))));
      send_byte(tail);
   endtask

   task automatic send_random_string();
      int n_parts;
      int i;
      int r;
      logic [7:0]  c;
      logic [15:0] cu;
      // whitespace and the odd stray byte before the quote
      n_parts = $urandom_range(0, 2);
      for (i = 0; i < n_parts; i++) begin
         case ($urandom_range(0, 3))
            0: send_byte(CH_SPACE);
            1: send_byte(CH_TAB);
            2: send_byte(CH_CR);
            default: send_byte(CH_LF);
         endcase
      end
      if ($urandom_range(0, 19) == 0) begin
         if ($urandom_range(0, 4) == 0) c = CH_NUL;
         else begin
            do c = 8'($urandom_range(1, 255));
            while (c == CH_QUOTE || c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF);
         end
         send_byte(c);
      end
      send_byte(CH_QUOTE);

      // string body
      n_parts = $urandom_range(0, 8);
      for (i = 0; i < n_parts; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) send_byte(pick_plain());
         else if (r < 60) begin
            send_byte(CH_BSLASH);
            send_byte(pick_escaped());
         end else if (r < 88) send_unit(pick_unit($urandom_range(0, 3)));
         else begin
            send_unit(16'($urandom_range(16'hd800, 16'hdbff)));
            send_unit(16'($urandom_range(16'hdc00, 16'hdfff)));
         end
      end

      // mostly a closing quote, otherwise a broken ending
      r = $urandom_range(0, 99);
      if (r < 76) send_byte(CH_QUOTE);
      else if (r < 79) send_byte(CH_NUL);
      else if (r < 81) begin
         send_byte(CH_BSLASH);
         send_byte(CH_NUL);
      end else if (r < 86) begin
         do c = 8'($urandom_range(1, 255)); while (hex_digit(c) != 5'd0 && c != 8'h00);
         while (hex_digit(c) != 5'd0) c = 8'($urandom_range(1, 255));
         send_cut_unit(c);
      end else if (r < 88) send_cut_unit(CH_NUL);
      else begin
         send_unit(16'($urandom_range(16'hd800, 16'hdbff)));
         r = $urandom_range(0, 9);
         if (r < 3) begin
            // something other than a backslash after the high half
            do c = 8'($urandom_range(1, 255)); while (c == CH_BSLASH);
            send_byte(c);
         end else if (r < 5) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_LOW_U);
            send_byte(CH_BSLASH);
            send_byte(c);
         end else if (r < 6) send_byte(CH_NUL);
         else if (r < 7) begin
            send_byte(CH_BSLASH);
            send_byte(CH_NUL);
         end else begin
            // second unit is not a low surrogate
            do cu = 16'($urandom_range(0, 16'hffff)); while (cu[15:10] == SURR_LOW_TAG);
            send_unit(cu);
         end
      end
   endtask

   // ----------------------------------------------------------------------
   // Result side: check, random stalls, watchdog
   // ----------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      beat_type due;
      int    r;
      int    stall_left;
      int    idle_cycles;
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_left  = 0;
         idle_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (beats_due.size() == 0) begin
               $error("unexpected beat: kind %0d out_byte %02h error_code %0d last %0d",
                      rsp_kind, rsp_out_byte, rsp_error_code, rsp_last);
               n_fail++;
            end else begin
               due = beats_due.pop_front();
               if (rsp_kind !== due.kind) begin
                  $error("kind: expected %0d, got %0d", due.kind, rsp_kind);
                  n_fail++;
               end
               if (rsp_out_byte !== due.data) begin
                  $error("out_byte: expected %02h, got %02h", due.data, rsp_out_byte);
                  n_fail++;
               end
               if (rsp_error_code !== due.err) begin
                  $error("error_code: expected %0d, got %0d", due.err, rsp_error_code);
                  n_fail++;
               end
               if (rsp_last !== due.last_beat) begin
                  $error("last: expected %0d, got %0d", due.last_beat, rsp_last);
                  n_fail++;
               end
            end
            case (rsp_kind)
               KIND_DATA: n_data++;
               KIND_DONE: n_done++;
               default:   n_err++;
            endcase
         end

         // back-pressure: mostly short stalls, now and then a long one
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm) begin
               r = $urandom_range(0, 99);
               if (r >= 93) stall_left = $urandom_range(8, 40);
               else if (r >= 65) stall_left = $urandom_range(1, 3);
            end
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // ----------------------------------------------------------------------
   // Stimulus
   // ----------------------------------------------------------------------
   initial begin : stimulus
      int i;
      int n_strings;
      clear_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_SCRIPT; i++) send_byte(SCRIPT[i].ch, SCRIPT[i].typed, SCRIPT[i].want);

      n_strings = 0;
      while (n_sent < TARGET_BYTES) begin
         calm = ($urandom_range(0, 4) == 0);
         send_random_string();
         n_strings++;
         if (n_strings % 8 == 0) drain();
      end
      calm = 1'b0;

      drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d input bytes: the script, then %0d random strings.", n_sent, n_strings);
      $display("Saw %0d data, %0d string-end and %0d error beats.", n_data, n_done, n_err);
      if (n_fail == 0 && beats_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
